>>> rtl/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and constants for the splitmix64 random source: mixing
// constants, request modes and the control/status bundles between the
// sequencer and the datapath.
// ----------------------------------------------------------------------------
package smx_pkg;

   localparam logic [63:0] GOLDEN_STEP  = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
   localparam logic [63:0] FRACTION_ONE = 64'h0020_0000_0000_0000;

   localparam int unsigned REQ_DATA_W = 136;
   localparam int unsigned RSP_DATA_W = 72;

   // request modes
   localparam logic [1:0] OP_RAW       = 2'd0;
   localparam logic [1:0] OP_UNIFORM   = 2'd1;
   localparam logic [1:0] OP_INDEX     = 2'd2;
   localparam logic [1:0] OP_BERNOULLI = 2'd3;

   // last step of one 64 by 64 product: four partial products plus a drain
   localparam logic [2:0] MUL_LAST_STEP = 3'd4;

   typedef struct packed {
      logic       load;      // request transfer, latch operands
      logic       mul_run;   // one step of the partial product sequence
      logic [2:0] step;      // partial product step
      logic       prep2;     // second mixing round operands
      logic       prep3;     // final xor-shift, index product operands
      logic       out_load;  // load the result register
   } ctl_cmd_type;

   typedef struct packed {
      logic req_error;  // request on the input bus would be refused
      logic is_index;   // latched request is an index draw
   } dp_status_type;

endpackage

>>> rtl/smx_ctrl.sv
// ----------------------------------------------------------------------------
// smx_ctrl
// Sequencer for the splitmix64 random source. Steps the shared multiplier
// through the two mixing rounds and the optional index product, and owns
// the handshake of both streams.
// ----------------------------------------------------------------------------
module smx_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  smx_pkg::dp_status_type status,
   output smx_pkg::ctl_cmd_type   cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MIX1  = 3'd1;
   localparam logic [2:0] S_PREP2 = 3'd2;
   localparam logic [2:0] S_MIX2  = 3'd3;
   localparam logic [2:0] S_PREP3 = 3'd4;
   localparam logic [2:0] S_MUL3  = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.step     = step_ff;
      case (state_ff)
         S_IDLE: begin
            step_in = 3'd0;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.req_error ? S_OUT : S_MIX1;
            end
         end
         S_MIX1, S_MIX2, S_MUL3: begin
            cmd.mul_run = 1'b1;
            if (step_ff == smx_pkg::MUL_LAST_STEP) begin
               step_in = 3'd0;
               case (state_ff)
                  S_MIX1:  state_in = S_PREP2;
                  S_MIX2:  state_in = S_PREP3;
                  default: state_in = S_OUT;
               endcase
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         S_PREP2: begin
            cmd.prep2 = 1'b1;
            state_in  = S_MIX2;
         end
         S_PREP3: begin
            cmd.prep3 = 1'b1;
            state_in  = status.is_index ? S_MUL3 : S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // a refused request skips all arithmetic
   a_err_skips: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && status.req_error) |=> (state_ff == S_OUT))
      else $error("refused request did not go straight to output");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= smx_pkg::MUL_LAST_STEP)
      else $error("multiplier step out of range");

   // a waiting result must never be overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while held");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

>>> rtl/smx_dpath.sv
// ----------------------------------------------------------------------------
// smx_dpath
// Datapath of the splitmix64 random source: counter, operand registers, a
// shared 32x32 multiplier with a 128-bit accumulator, and the result
// register.
// ----------------------------------------------------------------------------
module smx_dpath (
   input  logic                                 clock,
   input  logic                                 csr_we,
   input  logic [63:0]                          csr_wdata,
   input  logic                                 reset,
   input  logic [smx_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic [smx_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  smx_pkg::ctl_cmd_type                 cmd,
   output smx_pkg::dp_status_type               status
);

   logic [1:0]   req_op;
   logic [63:0]  req_bound;
   logic [63:0]  req_prob;
   logic         req_error;

   logic [63:0]  counter_ff, counter_in;
   logic [1:0]   op_ff;
   logic [63:0]  bound_ff;
   logic [63:0]  prob_ff;
   logic         err_ff;
   logic [63:0]  mul_a_ff, mul_b_ff;
   logic [63:0]  prod_ff;
   logic [1:0]   pp_sel_ff;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  word_ff;
   logic [63:0]  value_ff;
   logic         error_ff;

   logic [63:0]  next_count;
   logic [31:0]  mul_x, mul_y;
   logic [63:0]  mul_prod;
   logic [127:0] pp_shift;
   logic [63:0]  round2_z;
   logic [63:0]  mix_word;
   logic [52:0]  u53;
   logic [63:0]  result;

   assign req_op    = req_tdata[1:0];
   assign req_bound = req_tdata[65:2];
   assign req_prob  = req_tdata[129:66];

   assign req_error = ((req_op == smx_pkg::OP_INDEX) && (req_bound == 64'd0)) ||
                      ((req_op == smx_pkg::OP_BERNOULLI) &&
                       (req_prob > smx_pkg::FRACTION_ONE));

   assign status.req_error = req_error;
   assign status.is_index  = (op_ff == smx_pkg::OP_INDEX);

   assign next_count = counter_ff + smx_pkg::GOLDEN_STEP;

   always_comb begin
      if (csr_we) begin
         counter_in = csr_wdata;
      end else if (cmd.load && !req_error) begin
         counter_in = next_count;
      end else begin
         counter_in = counter_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= 64'd0;
      end else begin
         counter_ff <= counter_in;
      end
   end

   // partial product order: lo*lo, hi*lo, lo*hi, hi*hi
   always_comb begin
      case (cmd.step[1:0])
         2'd0: begin
            mul_x = mul_a_ff[31:0];
            mul_y = mul_b_ff[31:0];
         end
         2'd1: begin
            mul_x = mul_a_ff[63:32];
            mul_y = mul_b_ff[31:0];
         end
         2'd2: begin
            mul_x = mul_a_ff[31:0];
            mul_y = mul_b_ff[63:32];
         end
         default: begin
            mul_x = mul_a_ff[63:32];
            mul_y = mul_b_ff[63:32];
         end
      endcase
   end

   assign mul_prod = mul_x * mul_y;

   always_comb begin
      case (pp_sel_ff)
         2'd0:    pp_shift = {64'd0, prod_ff};
         2'd1,
         2'd2:    pp_shift = {32'd0, prod_ff, 32'd0};
         default: pp_shift = {prod_ff, 64'd0};
      endcase
   end

   assign round2_z = acc_ff[63:0] ^ (acc_ff[63:0] >> 27);
   assign mix_word = acc_ff[63:0] ^ (acc_ff[63:0] >> 31);
   assign u53      = word_ff[63:11];

   always_comb begin
      acc_in = acc_ff;
      if (cmd.load || cmd.prep2 || cmd.prep3) begin
         acc_in = 128'd0;
      end else if (cmd.mul_run && (cmd.step != 3'd0)) begin
         acc_in = acc_ff + pp_shift;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.load) begin
         op_ff    <= req_op;
         bound_ff <= req_bound;
         prob_ff  <= req_prob;
         err_ff   <= req_error;
         mul_a_ff <= next_count ^ (next_count >> 30);
         mul_b_ff <= smx_pkg::MIX_MUL_A;
      end else if (cmd.prep2) begin
         mul_a_ff <= round2_z;
         mul_b_ff <= smx_pkg::MIX_MUL_B;
      end else if (cmd.prep3) begin
         word_ff  <= mix_word;
         mul_a_ff <= {11'd0, mix_word[63:11]};
         mul_b_ff <= bound_ff;
      end
      if (cmd.mul_run && (cmd.step != smx_pkg::MUL_LAST_STEP)) begin
         prod_ff   <= mul_prod;
         pp_sel_ff <= cmd.step[1:0];
      end
   end

   always_comb begin
      case (op_ff)
         smx_pkg::OP_RAW:     result = word_ff;
         smx_pkg::OP_UNIFORM: result = {11'd0, u53};
         smx_pkg::OP_INDEX:   result = acc_ff[116:53];
         default:             result = {63'd0, ({11'd0, u53} < prob_ff)};
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         value_ff <= err_ff ? 64'd0 : result;
         error_ff <= err_ff;
      end
   end

   assign rsp_tdata = {7'd0, error_ff, value_ff};

endmodule

>>> rtl/splitmix64_random_source.sv
// ----------------------------------------------------------------------------
// splitmix64_random_source
// Counter-based splitmix64 generator answering raw, uniform, bounded index
// and Bernoulli requests, one request in flight at a time.
// ----------------------------------------------------------------------------
// a request runs the first mixing round, the second mixing round and, for index,
//   the bounded product before its result is loaded; a refused request skips them
// no new request is taken until the previous result is loaded, and each product
//   uses the single 32x32 multiplier for four partial products
// a new request is taken while the previous result waits for its transfer
// reset: synchronous, clears the counter to zero and drops rsp_tvalid
module splitmix64_random_source (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [63:0]  csr_wdata,   // seed
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // op[1:0], bound[65:2], probability[129:66], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata    // value[63:0], error[64], zero pad
);

   smx_pkg::ctl_cmd_type   cmd;
   smx_pkg::dp_status_type status;

   smx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   smx_dpath u_dpath (
      .clock      (clock),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
